// ===== src/psq_pkg.sv =====
// Shared types and constants for the P-square quantile estimator.
// Used by psq_muldiv and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package psq_pkg;

    localparam int MD_W = 64;                    // shared unit operand width
    localparam int FRAC = 17;                    // desired position fraction bits
    localparam int SLOPE_SHIFT = 16;             // extra slope fraction bits
    localparam logic [15:0] P_RESET = 16'd32768;
    localparam logic [MD_W-1:0] SLOPE_SCALE = MD_W'(65536);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_REQ,
        ST_WAIT,
        ST_APPLY,
        ST_DONE
    } seq_state_t;

    typedef enum logic [2:0] {
        OP_S1,
        OP_S0,
        OP_T1,
        OP_T0,
        OP_LIN
    } op_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_DONE
    } md_state_t;

    typedef struct packed {
        logic            start;
        logic [MD_W-1:0] a;
        logic [MD_W-1:0] b;
        logic [MD_W-1:0] c;
    } md_req_t;

    typedef struct packed {
        logic            done;
        logic [MD_W-1:0] q;
    } md_rsp_t;

endpackage
`default_nettype wire

// ===== src/psq_muldiv.sv =====
// Shared iterative unit: floor(a*b/c), saturating, c of zero gives all ones.
// Shift-add multiply one multiplier bit a cycle, then restoring divide. Uses psq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psq_muldiv
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire psq_pkg::md_req_t req,
    output psq_pkg::md_rsp_t      rsp
);

    localparam int W  = psq_pkg::MD_W;
    localparam int CW = $clog2(W);

    psq_pkg::md_state_t state_reg, state_next;
    logic [2*W-1:0] acc_reg, acc_next;
    logic [2*W-1:0] mcand_reg, mcand_next;
    logic [W-1:0]   mplier_reg, mplier_next;
    logic [W-1:0]   div_reg, div_next;
    logic [W-1:0]   rem_reg, rem_next;
    logic [W-1:0]   lo_reg, lo_next;
    logic [W-1:0]   q_reg, q_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]   hi;
    logic [W-1:0]   r2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psq_pkg::MD_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        lo_reg     <= lo_next;
        q_reg      <= q_next;
        cnt_reg    <= cnt_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        div_next    = div_reg;
        rem_next    = rem_reg;
        lo_next     = lo_reg;
        q_next      = q_reg;
        cnt_next    = cnt_reg;
        hi          = acc_reg[2*W-1:W];
        r2          = {rem_reg[W-2:0], lo_reg[W-1]};
        case (state_reg)
            psq_pkg::MD_IDLE:
            begin
                if (req.start)
                begin
                    acc_next    = '0;
                    mcand_next  = {{W{1'b0}}, req.a};
                    mplier_next = req.b;
                    div_next    = req.c;
                    state_next  = psq_pkg::MD_MUL;
                end
            end
            psq_pkg::MD_MUL:
            begin
                if (mplier_reg == '0)
                begin
                    // overflowing quotient or zero divisor saturates
                    if (div_reg == '0 || hi >= div_reg)
                    begin
                        q_next     = '1;
                        state_next = psq_pkg::MD_DONE;
                    end
                    else
                    begin
                        rem_next   = hi;
                        lo_next    = acc_reg[W-1:0];
                        q_next     = '0;
                        cnt_next   = '0;
                        state_next = psq_pkg::MD_DIV;
                    end
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        acc_next = acc_reg + mcand_reg;
                    end
                    mcand_next  = {mcand_reg[2*W-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[W-1:1]};
                end
            end
            psq_pkg::MD_DIV:
            begin
                if (rem_reg[W-1] || r2 >= div_reg)
                begin
                    rem_next = r2 - div_reg;
                    q_next   = {q_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = r2;
                    q_next   = {q_reg[W-2:0], 1'b0};
                end
                lo_next  = {lo_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(W - 1))
                begin
                    state_next = psq_pkg::MD_DONE;
                end
            end
            psq_pkg::MD_DONE:
            begin
                state_next = psq_pkg::MD_IDLE;
            end
            default:
            begin
                state_next = psq_pkg::MD_IDLE;
            end
        endcase
    end

    assign rsp.done = (state_reg == psq_pkg::MD_DONE);
    assign rsp.q    = q_reg;

endmodule
`default_nettype wire

// ===== src/p_square_quantile_estimator_core.sv =====
// Top level of the five-marker P-square running quantile estimator.
// Depends on psq_pkg and psq_muldiv.
//
// Usage:
//   Input channel (in_valid/in_ready, sample): one signed Q16.16 observation
//   per transaction. Output channel (out_valid/out_ready, estimate, ready_res):
//   exactly one result per input transaction, in order.
//   Config channel (cfg_valid/cfg_ready, cfg_data): writes quantile_p,
//   p = cfg_data / 65536; always ready, write only while the block is idle.
// Sequencing:
//   One item at a time. A warm-up sample goes from the idle state through the
//   done state to the output register. A later sample is checked against each
//   of the three inner markers in turn and, for each inner marker that moves,
//   takes four or five passes through the shared mul/div unit, each a shift-add
//   multiply and, unless the quotient saturates, a 64-step divide.
// Reset: markers cleared, positions 1..5, quantile_p = 0.5, no result pending.
// Stall: a finished result sits in the output register; the next input is
//   taken meanwhile, and its result waits until the register frees up.
`timescale 1ns / 1ps
`default_nettype none
module p_square_quantile_estimator_core
#(
    parameter int SAMPLE_WIDTH   = 32,
    parameter int POSITION_WIDTH = 32
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [31:0]                  estimate,
    output logic                                ready_res,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [15:0]                    cfg_data
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int PW   = POSITION_WIDTH;
    localparam int FR   = psq_pkg::FRAC;
    localparam int MW   = psq_pkg::MD_W;
    localparam int DW   = (PW + FR > MW) ? MW : PW + FR;
    localparam logic [PW-1:0] PMAX = {PW{1'b1}};
    localparam logic [DW-1:0] DCAP = (PW + FR >= MW) ? {DW{1'b1}}
                                   : DW'({{PW{1'b1}}, {FR{1'b0}}});
    localparam logic [DW-1:0] ONE  = DW'(1) << FR;

    psq_pkg::seq_state_t state_reg, state_next;
    psq_pkg::op_t        op_reg, op_next;

    logic signed [SW-1:0] h_reg [5];
    logic signed [SW-1:0] h_next [5];
    logic [PW-1:0]        pos_reg [5];
    logic [PW-1:0]        pos_next [5];
    logic [DW-1:0]        des_reg [5];
    logic [DW-1:0]        des_next [5];
    logic [2:0]           wcnt_reg, wcnt_next;
    logic [15:0]          p_reg, p_next;
    logic [1:0]           j_reg, j_next;
    logic                 up_reg, up_next;
    logic [MW-1:0]        s1_reg, s1_next;
    logic [MW-1:0]        s0_reg, s0_next;
    logic [MW-1:0]        t1_reg, t1_next;
    logic [MW-1:0]        move_reg, move_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [31:0]   est_reg, est_next;
    logic                 rdy_reg, rdy_next;

    psq_pkg::md_req_t md_req;
    psq_pkg::md_rsp_t md_rsp;

    // neighborhood of the marker under adjustment
    logic signed [SW-1:0] hl, hm, hh;
    logic [PW-1:0]        nl, nm, nh;
    logic [DW-1:0]        dm;
    logic [MW-1:0]        n64, nint64, nceil64;
    logic [PW-1:0]        w1, w0;
    logic [PW:0]          bw, cw, wsum;
    logic [SW-1:0]        d1, d0;
    logic [MW-1:0]        dq1, dq0;
    logic                 adj_up, adj_down;
    logic [MW:0]          sum_full;
    logic [MW-1:0]        delta;
    logic                 ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psq_pkg::ST_IDLE;
            op_reg        <= psq_pkg::OP_S1;
            wcnt_reg      <= '0;
            p_reg         <= psq_pkg::P_RESET;
            j_reg         <= 2'd1;
            up_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 5; i++)
            begin
                h_reg[i]   <= '0;
                pos_reg[i] <= PW'(i + 1);
                des_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            wcnt_reg      <= wcnt_next;
            p_reg         <= p_next;
            j_reg         <= j_next;
            up_reg        <= up_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 5; i++)
            begin
                h_reg[i]   <= h_next[i];
                pos_reg[i] <= pos_next[i];
                des_reg[i] <= des_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg   <= s1_next;
        s0_reg   <= s0_next;
        t1_reg   <= t1_next;
        move_reg <= move_next;
        est_reg  <= est_next;
        rdy_reg  <= rdy_next;
    end

    psq_muldiv u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    // marker neighborhood and move decision
    always_comb
    begin
        case (j_reg)
            2'd1:
            begin
                hl = h_reg[0];   hm = h_reg[1];   hh = h_reg[2];
                nl = pos_reg[0]; nm = pos_reg[1]; nh = pos_reg[2];
                dm = des_reg[1];
            end
            2'd2:
            begin
                hl = h_reg[1];   hm = h_reg[2];   hh = h_reg[3];
                nl = pos_reg[1]; nm = pos_reg[2]; nh = pos_reg[3];
                dm = des_reg[2];
            end
            default:
            begin
                hl = h_reg[2];   hm = h_reg[3];   hh = h_reg[4];
                nl = pos_reg[2]; nm = pos_reg[3]; nh = pos_reg[4];
                dm = des_reg[3];
            end
        endcase
        n64     = MW'(nm);
        nint64  = MW'(dm[DW-1:FR]);
        nceil64 = nint64 + MW'(|dm[FR-1:0]);
        w1      = (nh > nm) ? nh - nm : '0;
        w0      = (nm > nl) ? nm - nl : '0;
        adj_up   = (nint64 > n64) && (w1 > PW'(1));
        adj_down = (nceil64 < n64) && (w0 > PW'(1));
        d1      = SW'(hh - hm);
        d0      = SW'(hm - hl);
        dq1     = (hh > hm) ? MW'(d1) : '0;
        dq0     = (hm > hl) ? MW'(d0) : '0;
        bw      = up_reg ? {1'b0, w0} + (PW+1)'(1) : {1'b0, w0} - (PW+1)'(1);
        cw      = up_reg ? {1'b0, w1} - (PW+1)'(1) : {1'b0, w1} + (PW+1)'(1);
        wsum    = {1'b0, w0} + {1'b0, w1};
        sum_full = {1'b0, t1_reg} + {1'b0, md_rsp.q};
        delta    = (sum_full[MW] ? {MW{1'b1}} : sum_full[MW-1:0]) >> psq_pkg::SLOPE_SHIFT;
        ok       = up_reg ? (delta < dq1 && (dq0 != '0 || delta != '0))
                          : (delta < dq0 && (dq1 != '0 || delta != '0));
    end

    // shared unit operands
    always_comb
    begin
        md_req.start = (state_reg == psq_pkg::ST_REQ);
        case (op_reg)
            psq_pkg::OP_S1:
            begin
                md_req.a = dq1; md_req.b = psq_pkg::SLOPE_SCALE; md_req.c = MW'(w1);
            end
            psq_pkg::OP_S0:
            begin
                md_req.a = dq0; md_req.b = psq_pkg::SLOPE_SCALE; md_req.c = MW'(w0);
            end
            psq_pkg::OP_T1:
            begin
                md_req.a = s1_reg; md_req.b = MW'(bw); md_req.c = MW'(wsum);
            end
            psq_pkg::OP_T0:
            begin
                md_req.a = s0_reg; md_req.b = MW'(cw); md_req.c = MW'(wsum);
            end
            default:
            begin
                md_req.a = up_reg ? dq1 : dq0;
                md_req.b = MW'(1);
                md_req.c = up_reg ? MW'(w1) : MW'(w0);
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        logic signed [SW-1:0] x;
        logic [2:0]           ins;
        logic [2:0]           wnew;
        logic [1:0]           k;
        logic [DW:0]          dsum;
        logic [DW-1:0]        step [5];

        x    = sample;
        ins  = '0;
        wnew = wcnt_reg + 3'd1;
        k    = '0;
        dsum = '0;
        step[0] = '0;
        step[1] = DW'(p_reg);
        step[2] = DW'({p_reg, 1'b0});
        step[3] = (ONE >> 1) + DW'(p_reg);
        step[4] = ONE;

        state_next     = state_reg;
        op_next        = op_reg;
        wcnt_next      = wcnt_reg;
        p_next         = p_reg;
        j_next         = j_reg;
        up_next        = up_reg;
        s1_next        = s1_reg;
        s0_next        = s0_reg;
        t1_next        = t1_reg;
        move_next      = move_reg;
        est_next       = est_reg;
        rdy_next       = rdy_reg;
        out_valid_next = out_valid_reg;
        for (int i = 0; i < 5; i++)
        begin
            h_next[i]   = h_reg[i];
            pos_next[i] = pos_reg[i];
            des_next[i] = des_reg[i];
        end

        if (cfg_valid)
        begin
            p_next = cfg_data;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            psq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (wcnt_reg < 3'd5)
                    begin
                        // sorted insert, after equal entries
                        for (int i = 0; i < 4; i++)
                        begin
                            if (3'(i) < wcnt_reg && h_reg[i] <= x)
                            begin
                                ins = ins + 3'd1;
                            end
                        end
                        if (ins == 3'd0)
                        begin
                            h_next[0] = x;
                        end
                        for (int i = 1; i < 5; i++)
                        begin
                            if (3'(i) == ins)
                            begin
                                h_next[i] = x;
                            end
                            else if (3'(i) > ins && 3'(i) <= wcnt_reg)
                            begin
                                h_next[i] = h_reg[i-1];
                            end
                        end
                        wcnt_next = wnew;
                        if (wnew == 3'd5)
                        begin
                            des_next[0] = ONE;
                            des_next[1] = ONE + DW'({p_reg, 2'b00});
                            des_next[2] = ONE + DW'({p_reg, 3'b000});
                            des_next[3] = (ONE << 1) + ONE + DW'({p_reg, 2'b00});
                            des_next[4] = (ONE << 2) + ONE;
                        end
                        state_next = psq_pkg::ST_DONE;
                    end
                    else
                    begin
                        if (x < h_reg[0])
                        begin
                            h_next[0] = x;
                            k = 2'd0;
                        end
                        else if (x >= h_reg[4])
                        begin
                            h_next[4] = x;
                            k = 2'd3;
                        end
                        else
                        begin
                            k = 2'(h_reg[1] <= x) + 2'(h_reg[2] <= x) + 2'(h_reg[3] <= x);
                        end
                        for (int i = 1; i < 5; i++)
                        begin
                            if (3'(i) > {1'b0, k} && pos_reg[i] < PMAX)
                            begin
                                pos_next[i] = pos_reg[i] + PW'(1);
                            end
                        end
                        for (int i = 0; i < 5; i++)
                        begin
                            dsum = {1'b0, des_reg[i]} + {1'b0, step[i]};
                            des_next[i] = (dsum > {1'b0, DCAP}) ? DCAP : dsum[DW-1:0];
                        end
                        j_next     = 2'd1;
                        state_next = psq_pkg::ST_EVAL;
                    end
                end
            end
            psq_pkg::ST_EVAL:
            begin
                if (adj_up || adj_down)
                begin
                    up_next    = adj_up;
                    op_next    = psq_pkg::OP_S1;
                    state_next = psq_pkg::ST_REQ;
                end
                else if (j_reg == 2'd3)
                begin
                    state_next = psq_pkg::ST_DONE;
                end
                else
                begin
                    j_next = j_reg + 2'd1;
                end
            end
            psq_pkg::ST_REQ:
            begin
                state_next = psq_pkg::ST_WAIT;
            end
            psq_pkg::ST_WAIT:
            begin
                if (md_rsp.done)
                begin
                    case (op_reg)
                        psq_pkg::OP_S1:
                        begin
                            s1_next    = md_rsp.q;
                            op_next    = psq_pkg::OP_S0;
                            state_next = psq_pkg::ST_REQ;
                        end
                        psq_pkg::OP_S0:
                        begin
                            s0_next    = md_rsp.q;
                            op_next    = psq_pkg::OP_T1;
                            state_next = psq_pkg::ST_REQ;
                        end
                        psq_pkg::OP_T1:
                        begin
                            t1_next    = md_rsp.q;
                            op_next    = psq_pkg::OP_T0;
                            state_next = psq_pkg::ST_REQ;
                        end
                        psq_pkg::OP_T0:
                        begin
                            // fall back to the linear step if the parabola overshoots
                            if (ok)
                            begin
                                move_next  = delta;
                                state_next = psq_pkg::ST_APPLY;
                            end
                            else
                            begin
                                op_next    = psq_pkg::OP_LIN;
                                state_next = psq_pkg::ST_REQ;
                            end
                        end
                        default:
                        begin
                            move_next  = md_rsp.q;
                            state_next = psq_pkg::ST_APPLY;
                        end
                    endcase
                end
            end
            psq_pkg::ST_APPLY:
            begin
                h_next[3'(j_reg)]   = up_reg ? hm + SW'(move_reg) : hm - SW'(move_reg);
                pos_next[3'(j_reg)] = up_reg ? nm + PW'(1) : nm - PW'(1);
                if (j_reg == 2'd3)
                begin
                    state_next = psq_pkg::ST_DONE;
                end
                else
                begin
                    j_next     = j_reg + 2'd1;
                    state_next = psq_pkg::ST_EVAL;
                end
            end
            psq_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    est_next       = (wcnt_reg == 3'd5) ? 32'(h_reg[2]) : '0;
                    rdy_next       = (wcnt_reg == 3'd5);
                    state_next     = psq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psq_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == psq_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign estimate  = est_reg;
    assign ready_res = rdy_reg;

endmodule
`default_nettype wire

// ===== src/psq_checker.sv =====
// Port-level checker for the P-square quantile estimator, bound to the top level.
// Depends on p_square_quantile_estimator_core only through its ports.
`timescale 1ns / 1ps
`default_nettype none
module psq_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [31:0] estimate,
    input wire logic               ready_res,
    input wire logic               cfg_valid,
    input wire logic               cfg_ready
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(estimate) && $stable(ready_res))
        else $error("stalled result changed");

    // warm-up results carry a zero estimate
    a_warm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ready_res |-> estimate == 32'sd0)
        else $error("nonzero estimate during warm-up");

    // one item at a time: busy right after a transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind p_square_quantile_estimator_core psq_checker u_psq_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .estimate  (estimate),
    .ready_res (ready_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
`default_nettype wire
